// ===== src/wlm_pkg.sv =====
// ----------------------------------------------------------------------------
// wlm_pkg: shared types and constants for the window/level mapper
// Payload structs, configuration codes and the control word that travels
// down the pipeline next to the data.
// ----------------------------------------------------------------------------
package wlm_pkg;

	// default number of fraction bits of slope and intercept
	localparam int unsigned FRAC_BITS_DEF = 16;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_CODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIGNED     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLOPE      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INTERCEPT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPAN       = 3'd5;

	// sample width codes
	localparam logic [1:0] WCODE_8  = 2'd0;
	localparam logic [1:0] WCODE_16 = 2'd1;

	// reset values
	localparam logic [1:0]  WIDTH_CODE_RST = WCODE_16;
	localparam logic [31:0] SLOPE_RST      = 32'h0001_0000;
	localparam logic [31:0] INTERCEPT_RST  = 32'h0000_0000;
	localparam logic [17:0] CENTER_RST     = 18'd0;
	localparam logic [18:0] SPAN_RST       = 19'd65536;

	typedef struct packed {
		logic [15:0] raw_sample;
		logic        last_in;
	} sample_t;

	typedef struct packed {
		logic [7:0] display_value;
		logic       last_out;
	} result_t;

	typedef struct packed {
		logic [1:0]  sample_width_code;
		logic        samples_signed;
		logic [31:0] rescale_slope;
		logic [31:0] rescale_intercept;
		logic [17:0] window_center;
		logic [18:0] window_span;
	} cfg_t;

	// per-beat control word carried along the pipeline
	typedef struct packed {
		logic       valid;
		logic       last;
		logic [7:0] bypass;
	} ctl_t;

	// a zero span behaves as a span of one
	function automatic logic [18:0] span_eff(input logic [18:0] span);
		span_eff = (span == 19'd0) ? 19'd1 : span;
	endfunction

endpackage

// ===== src/wlm_rescale.sv =====
// ----------------------------------------------------------------------------
// wlm_rescale: front half of the mapper pipeline
// Four stages: slope multiply, intercept and center, half-span offset,
// times 255. Also forms the 8-bit bypass value.
// ----------------------------------------------------------------------------
module wlm_rescale
	import wlm_pkg::*;
#(
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
	parameter int unsigned NUM_W     = 60
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    in_valid,
	input  sample_t                 in_beat,
	input  cfg_t                    cfg,
	output ctl_t                    ctl_out,
	output logic signed [NUM_W-1:0] num_out
);

	localparam int unsigned P_W = 49;
	localparam int unsigned D_W = ((18 + FRAC_BITS > P_W) ? 18 + FRAC_BITS : P_W) + 1;
	localparam int unsigned T_W = NUM_W - 8;

	logic signed [16:0]      samp;
	logic [7:0]              byp;
	logic [D_W-1:0]          center_sh;
	logic [T_W-1:0]          span_sh;
	logic [18:0]             w_eff;

	logic signed [P_W-1:0]   prod_s1;
	logic signed [D_W-1:0]   diff_s2;
	logic signed [T_W-1:0]   t_s3;
	logic signed [NUM_W-1:0] num_s4;
	ctl_t                    ctl_s1, ctl_s2, ctl_s3, ctl_s4;

	// sample extension and 8-bit bypass value
	always_comb begin
		samp = cfg.samples_signed ? {in_beat.raw_sample[15], in_beat.raw_sample}
			: {1'b0, in_beat.raw_sample};
		case (cfg.sample_width_code)
			WCODE_8:  byp = cfg.samples_signed ? (in_beat.raw_sample[7:0] ^ 8'h80)
				: in_beat.raw_sample[7:0];
			default:  byp = 8'd0;
		endcase
	end

	// center and span moved onto the fixed-point grid
	assign w_eff     = span_eff(cfg.window_span);
	assign center_sh = {{(D_W-18-FRAC_BITS){cfg.window_center[17]}}, cfg.window_center,
		{FRAC_BITS{1'b0}}};
	assign span_sh   = T_W'(w_eff) << FRAC_BITS;

	// control word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (adv) begin
			ctl_s1 <= '{valid: in_valid, last: in_beat.last_in, bypass: byp};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	// arithmetic stages
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= samp * $signed(cfg.rescale_slope);
			diff_s2 <= {{(D_W-P_W){prod_s1[P_W-1]}}, prod_s1}
				+ {{(D_W-32){cfg.rescale_intercept[31]}}, cfg.rescale_intercept}
				- center_sh;
			t_s3    <= {{(T_W-D_W-1){diff_s2[D_W-1]}}, diff_s2, 1'b0} + span_sh;
			num_s4  <= {t_s3, 8'd0} - {{8{t_s3[T_W-1]}}, t_s3};
		end
	end

	assign ctl_out = ctl_s4;
	assign num_out = num_s4;

endmodule

// ===== src/wlm_divider.sv =====
// ----------------------------------------------------------------------------
// wlm_divider: back half of the mapper pipeline
// Range check against 256 doubled spans, then a restoring divide by the doubled
// span, one quotient bit per stage over eight stages.
// ----------------------------------------------------------------------------
module wlm_divider
	import wlm_pkg::*;
#(
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
	parameter int unsigned NUM_W     = 60
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  ctl_t                    ctl_in,
	input  logic signed [NUM_W-1:0] num_in,
	input  cfg_t                    cfg,
	output ctl_t                    ctl_out,
	output logic [7:0]              quot
);

	localparam int unsigned NSTEP = 8;

	logic [18:0]      w_eff;
	logic [NUM_W-1:0] den;
	logic [NUM_W-1:0] lim;
	logic             neg;

	logic [NUM_W-1:0] rem_s [0:NSTEP];
	logic [7:0]       quo_s [0:NSTEP];
	logic             sat_s [0:NSTEP];
	ctl_t             ctl_s [0:NSTEP];

	// divisor is twice the span on the fixed-point grid
	assign w_eff = span_eff(cfg.window_span);
	assign den   = NUM_W'(w_eff) << (FRAC_BITS + 1);
	assign lim   = den << NSTEP;
	assign neg   = num_in[NUM_W-1];

	// entry stage: clamp flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (adv) begin
			ctl_s[0] <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sat_s[0] <= !neg && (NUM_W'(num_in) >= lim);
			rem_s[0] <= neg ? '0 : NUM_W'(num_in);
			quo_s[0] <= 8'd0;
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar i = 0; i < NSTEP; i++) begin : g_step
		logic [NUM_W-1:0] dsh;
		logic             ge;

		assign dsh = den << (NSTEP - 1 - i);
		assign ge  = rem_s[i] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[i+1] <= '0;
			end else if (adv) begin
				ctl_s[i+1] <= ctl_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[i+1] <= ge ? rem_s[i] - dsh : rem_s[i];
				quo_s[i+1] <= {quo_s[i][6:0], ge};
				sat_s[i+1] <= sat_s[i];
			end
		end
	end

	assign ctl_out = ctl_s[NSTEP];
	assign quot    = sat_s[NSTEP] ? 8'hFF : quo_s[NSTEP];

endmodule

// ===== src/pixel_window_level_mapper_top.sv =====
// path: an accepted beat passes the rescale stages, range check, divide stages and output register
// throughput: one beat per cycle; a stalled result freezes the whole pipeline
// depth is set by the 17x32 slope multiply, three adder stages, the range
// check and an eight-stage restoring divide, plus the output register
// reset: pipeline emptied and registers back to 16-bit unsigned, slope 1.0,
// intercept 0, center 0, span 65536
// ----------------------------------------------------------------------------
// pixel_window_level_mapper_top: raw sample to 8-bit display value
// Configuration registers, the rescale and divide pipelines and the output
// register with the bypass select.
// ----------------------------------------------------------------------------
module pixel_window_level_mapper_top
	import wlm_pkg::*;
#(
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  sample_valid,
	output logic                  sample_ready,
	input  sample_t               sample,
	output logic                  result_valid,
	input  logic                  result_ready,
	output result_t               result
);

	localparam int unsigned D_W   = ((18 + FRAC_BITS > 49) ? 18 + FRAC_BITS : 49) + 1;
	localparam int unsigned T_W   = ((D_W + 1 > 19 + FRAC_BITS) ? D_W + 1 : 19 + FRAC_BITS) + 1;
	localparam int unsigned NUM_W = T_W + 8;

	cfg_t                    cfg_q;
	logic                    adv;
	ctl_t                    rs_ctl, dv_ctl;
	logic signed [NUM_W-1:0] rs_num;
	logic [7:0]              dv_quot;
	logic                    res_valid_q;
	result_t                 res_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_width_code <= WIDTH_CODE_RST;
			cfg_q.samples_signed    <= 1'b0;
			cfg_q.rescale_slope     <= SLOPE_RST;
			cfg_q.rescale_intercept <= INTERCEPT_RST;
			cfg_q.window_center     <= CENTER_RST;
			cfg_q.window_span       <= SPAN_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_WIDTH_CODE: cfg_q.sample_width_code <= cfg_data[1:0];
				REG_SIGNED:     cfg_q.samples_signed    <= cfg_data[0];
				REG_SLOPE:      cfg_q.rescale_slope     <= cfg_data[31:0];
				REG_INTERCEPT:  cfg_q.rescale_intercept <= cfg_data[31:0];
				REG_CENTER:     cfg_q.window_center     <= cfg_data[17:0];
				REG_SPAN:       cfg_q.window_span       <= cfg_data[18:0];
				default: ;
			endcase
		end
	end

	// whole pipeline moves unless the result is held
	assign adv          = !res_valid_q || result_ready;
	assign sample_ready = adv;

	wlm_rescale #(
		.FRAC_BITS (FRAC_BITS),
		.NUM_W     (NUM_W)
	) u_rescale (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (sample_valid),
		.in_beat  (sample),
		.cfg      (cfg_q),
		.ctl_out  (rs_ctl),
		.num_out  (rs_num)
	);

	wlm_divider #(
		.FRAC_BITS (FRAC_BITS),
		.NUM_W     (NUM_W)
	) u_divider (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.ctl_in  (rs_ctl),
		.num_in  (rs_num),
		.cfg     (cfg_q),
		.ctl_out (dv_ctl),
		.quot    (dv_quot)
	);

	// output register with mode select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= dv_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.display_value <= (cfg_q.sample_width_code == WCODE_16) ? dv_quot
				: dv_ctl.bypass;
			res_q.last_out      <= dv_ctl.last;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

`ifndef SYNTHESIS
	// a held result freezes the last divider stage
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(dv_ctl) && $stable(dv_quot))
		else $error("divider output moved during a stall");

	// a finished beat leaving the divider always lands in the output register
	a_beat_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && dv_ctl.valid) |=> result_valid)
		else $error("beat lost between divider and output register");

	// nothing new enters while the output is stalled
	a_no_entry_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |-> !sample_ready)
		else $error("input accepted while pipeline stalled");
`endif

endmodule

// ===== tb/wlm_window_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wlm_window_checker: scoreboard for the window/level mapper
// Mirrors the configuration writes, works out the display value of every
// sample beat taken by the block and compares it with the result beats in
// order. Hands the mismatch count and the number of results still owed to
// the testbench top.
// ----------------------------------------------------------------------------
module wlm_window_checker
	import wlm_pkg::*;
#(
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  sample_valid,
	input  logic                  sample_ready,
	input  sample_t               sample,
	input  logic                  result_valid,
	input  logic                  result_ready,
	input  result_t               result,
	output int                    mismatches,
	output int                    in_flight
);

	cfg_t    mirror_cfg;
	result_t pending_pixels[$];

	// display value of one sample under the current register settings
	function automatic result_t window_level_map(input sample_t px);
		longint  one;
		longint  level;
		longint  span;
		longint  num;
		longint  den;
		longint  quot;
		result_t px_out;
		one = longint'(1) << FRAC_BITS;
		px_out.last_out = px.last_in;
		case (mirror_cfg.sample_width_code)
			WCODE_8: begin
				px_out.display_value = mirror_cfg.samples_signed ?
					(px.raw_sample[7:0] ^ 8'h80) : px.raw_sample[7:0];
			end
			WCODE_16: begin
				if (mirror_cfg.samples_signed)
					level = longint'($signed(px.raw_sample));
				else
					level = longint'(px.raw_sample);
				// rescale into fixed point, then window around the center
				level = level * longint'($signed(mirror_cfg.rescale_slope))
					+ longint'($signed(mirror_cfg.rescale_intercept));
				span = longint'(mirror_cfg.window_span);
				// a zero span acts as a span of one
				if (span == 0)
					span = 1;
				num = 255 * (2 * (level - longint'($signed(mirror_cfg.window_center)) * one)
					+ span * one);
				den = 2 * span * one;
				if (num < 0) begin
					px_out.display_value = 8'd0;
				end else begin
					quot = num / den;
					px_out.display_value = (quot > 255) ? 8'd255 : quot[7:0];
				end
			end
			// unsupported widths give black
			default: px_out.display_value = 8'd0;
		endcase
		return px_out;
	endfunction

	// config mirror, prediction and in-order compare
	always @(posedge clk or negedge arst_n) begin : track
		result_t want_px;
		if (!arst_n) begin
			mirror_cfg.sample_width_code = WIDTH_CODE_RST;
			mirror_cfg.samples_signed    = 1'b0;
			mirror_cfg.rescale_slope     = SLOPE_RST;
			mirror_cfg.rescale_intercept = INTERCEPT_RST;
			mirror_cfg.window_center     = CENTER_RST;
			mirror_cfg.window_span       = SPAN_RST;
			pending_pixels.delete();
			mismatches = 0;
			in_flight  = 0;
		end else begin
			// writes to unknown indexes are dropped
			if (cfg_we) begin
				case (cfg_idx)
					REG_WIDTH_CODE: mirror_cfg.sample_width_code = cfg_data[1:0];
					REG_SIGNED:     mirror_cfg.samples_signed    = cfg_data[0];
					REG_SLOPE:      mirror_cfg.rescale_slope     = cfg_data[31:0];
					REG_INTERCEPT:  mirror_cfg.rescale_intercept = cfg_data[31:0];
					REG_CENTER:     mirror_cfg.window_center     = cfg_data[17:0];
					REG_SPAN:       mirror_cfg.window_span       = cfg_data[18:0];
					default: ;
				endcase
			end
			// result beat against the oldest prediction
			if (result_valid && result_ready) begin
				if (pending_pixels.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, got value %0d last %0b",
						$time, result.display_value, result.last_out);
					mismatches++;
				end else begin
					want_px = pending_pixels.pop_front();
					if (result.display_value !== want_px.display_value) begin
						$display("%0t: display_value mismatch, expected %0d, got %0d",
							$time, want_px.display_value, result.display_value);
						mismatches++;
					end
					if (result.last_out !== want_px.last_out) begin
						$display("%0t: last_out mismatch, expected %0b, got %0b",
							$time, want_px.last_out, result.last_out);
						mismatches++;
					end
				end
			end
			if (sample_valid && sample_ready)
				pending_pixels.insert(pending_pixels.size(), window_level_map(sample));
			in_flight = pending_pixels.size();
		end
	end

endmodule

// ===== tb/tb_pixel_window_level_mapper_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pixel_window_level_mapper_top: stimulus and verdict for the mapper
// Runs a directed pass over format, sign and window extremes, then random
// phases of windowed sample streams with varying sender gaps and result
// stalls. The checker beside the block does all the comparing.
// ----------------------------------------------------------------------------
module tb_pixel_window_level_mapper_top;
	import wlm_pkg::*;

	localparam int unsigned FRAC       = FRAC_BITS_DEF;
	localparam int          ITEM_COUNT = 850;
	localparam int          IDLE_LIMIT = 4000;
	localparam int          TAIL_WAIT  = 20;

	// register indexes and width codes the block has no use for
	localparam logic [CFG_IDX_W-1:0] REG_NONE_A   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_NONE_B   = 3'd7;
	localparam logic [1:0]           WCODE_NONE_A = 2'd2;
	localparam logic [1:0]           WCODE_NONE_B = 2'd3;

	logic                  clk;
	logic                  arst_n       = 1'b0;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx      = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  sample_valid = 1'b0;
	logic                  sample_ready;
	sample_t               sample       = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	result_t               result;
	int                    mismatches;
	int                    in_flight;

	int                    send_idle_pct  = 0;
	int                    recv_stall_pct = 0;
	int                    quiet_cycles   = 0;

	pixel_window_level_mapper_top #(
		.FRAC_BITS(FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	wlm_window_checker #(
		.FRAC_BITS(FRAC)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.mismatches(mismatches),
		.in_flight(in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side back-pressure
	initial begin
		forever begin
			@(negedge clk);
			result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// watchdog on cycles without any beat
	initial begin
		forever begin
			@(posedge clk);
			if ((sample_valid && sample_ready) || (result_valid && result_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// one sample beat, with random gaps ahead of it
	task automatic push_pixel(input logic [15:0] raw, input logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= '{raw_sample: raw, last_in: last};
		do @(posedge clk); while (!sample_ready);
		@(negedge clk);
	endtask

	// stop sending and wait until every result has come back
	task automatic drain_results();
		sample_valid <= 1'b0;
		do @(negedge clk); while (in_flight != 0);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(negedge clk);
	endtask

	// full register load, only with the pipeline empty
	task automatic load_window(input cfg_t c);
		drain_results();
		put_reg(REG_WIDTH_CODE, CFG_DATA_W'(c.sample_width_code));
		put_reg(REG_SIGNED, CFG_DATA_W'(c.samples_signed));
		put_reg(REG_SLOPE, c.rescale_slope);
		put_reg(REG_INTERCEPT, c.rescale_intercept);
		put_reg(REG_CENTER, CFG_DATA_W'(c.window_center));
		put_reg(REG_SPAN, CFG_DATA_W'(c.window_span));
		// unknown index, must not disturb anything
		put_reg($urandom_range(0, 1) ? REG_NONE_A : REG_NONE_B, $urandom());
		cfg_we <= 1'b0;
	endtask

	// random settings; mostly a window placed around a base sample
	task automatic pick_window(output cfg_t c, output logic [15:0] base, output int spread);
		int          pick;
		int unsigned slope_mag;
		int unsigned span_v;
		longint      slope;
		longint      icpt;
		longint      smp;
		longint      lvl;
		longint      reach;
		pick = $urandom_range(0, 9);
		c.samples_signed = 1'($urandom_range(0, 1));
		if (pick < 6)
			c.sample_width_code = WCODE_16;
		else if (pick < 8)
			c.sample_width_code = WCODE_8;
		else
			c.sample_width_code = $urandom_range(0, 1) ? WCODE_NONE_A : WCODE_NONE_B;
		base = 16'($urandom());
		if ($urandom_range(0, 3) == 0) begin
			c.rescale_slope     = $urandom();
			c.rescale_intercept = $urandom();
			c.window_center     = 18'($urandom());
			c.window_span       = 19'($urandom());
			spread = 32768;
		end else begin
			slope_mag = $urandom_range(1 << 12, 1 << 19);
			slope = $urandom_range(0, 1) ? -longint'(slope_mag) : longint'(slope_mag);
			icpt = longint'($urandom_range(0, 1 << 27)) - (longint'(1) << 26);
			span_v = $urandom_range(1, 1 << $urandom_range(1, 14));
			smp = c.samples_signed ? longint'($signed(base)) : longint'(base);
			lvl = (smp * slope + icpt) >>> FRAC;
			if (lvl > 131071)
				lvl = 131071;
			if (lvl < -131072)
				lvl = -131072;
			c.rescale_slope     = 32'(slope);
			c.rescale_intercept = 32'(icpt);
			c.window_center     = 18'(lvl);
			c.window_span       = 19'(span_v);
			// raw distance that covers the window once
			reach = (longint'(span_v) << FRAC) / longint'(slope_mag) + 2;
			spread = (reach > 32767) ? 32767 : int'(reach);
		end
	endtask

	initial begin : stimulus
		cfg_t        win;
		logic [15:0] base;
		logic [15:0] raw;
		int          spread;
		int          sent;
		int          phase;
		int          burst;

		// reset once
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// after reset: 16-bit unsigned, unit slope, wide window
		push_pixel(16'h0000, 1'b0);
		push_pixel(16'hFFFF, 1'b1);
		push_pixel(16'h8000, 1'b0);
		push_pixel(16'h7FFF, 1'b1);

		// 8-bit unsigned bypass, upper byte ignored
		load_window('{sample_width_code: WCODE_8, samples_signed: 1'b0,
			rescale_slope: SLOPE_RST, rescale_intercept: INTERCEPT_RST,
			window_center: CENTER_RST, window_span: SPAN_RST});
		push_pixel(16'hFF00, 1'b0);
		push_pixel(16'h00FF, 1'b1);
		push_pixel(16'h0080, 1'b0);

		// 8-bit signed, offset by half range
		load_window('{sample_width_code: WCODE_8, samples_signed: 1'b1,
			rescale_slope: SLOPE_RST, rescale_intercept: INTERCEPT_RST,
			window_center: CENTER_RST, window_span: SPAN_RST});
		push_pixel(16'h0000, 1'b0);
		push_pixel(16'h007F, 1'b0);
		push_pixel(16'h0080, 1'b1);
		push_pixel(16'hFFFF, 1'b0);

		// unsupported width codes give zero
		load_window('{sample_width_code: WCODE_NONE_A, samples_signed: 1'b0,
			rescale_slope: SLOPE_RST, rescale_intercept: INTERCEPT_RST,
			window_center: CENTER_RST, window_span: SPAN_RST});
		push_pixel(16'hFFFF, 1'b1);
		load_window('{sample_width_code: WCODE_NONE_B, samples_signed: 1'b1,
			rescale_slope: SLOPE_RST, rescale_intercept: INTERCEPT_RST,
			window_center: CENTER_RST, window_span: SPAN_RST});
		push_pixel(16'h5A5A, 1'b0);

		// most negative slope, top intercept and center, zero span
		load_window('{sample_width_code: WCODE_16, samples_signed: 1'b1,
			rescale_slope: 32'h8000_0000, rescale_intercept: 32'h7FFF_FFFF,
			window_center: 18'h1FFFF, window_span: 19'd0});
		push_pixel(16'h8000, 1'b0);
		push_pixel(16'h7FFF, 1'b1);
		push_pixel(16'h0000, 1'b0);
		push_pixel(16'hFFFF, 1'b0);

		// top slope, bottom intercept and center, widest span
		load_window('{sample_width_code: WCODE_16, samples_signed: 1'b0,
			rescale_slope: 32'h7FFF_FFFF, rescale_intercept: 32'h8000_0000,
			window_center: 18'h20000, window_span: 19'h7FFFF});
		push_pixel(16'hFFFF, 1'b1);
		push_pixel(16'h0000, 1'b0);
		push_pixel(16'h8000, 1'b0);

		// span of one, steps right at the center
		load_window('{sample_width_code: WCODE_16, samples_signed: 1'b1,
			rescale_slope: SLOPE_RST, rescale_intercept: INTERCEPT_RST,
			window_center: CENTER_RST, window_span: 19'd1});
		push_pixel(16'hFFFF, 1'b0);
		push_pixel(16'h0000, 1'b1);
		push_pixel(16'h0001, 1'b0);

		// random phases, each with fresh settings and idling
		sent  = 0;
		phase = 0;
		while (sent < ITEM_COUNT) begin
			pick_window(win, base, spread);
			load_window(win);
			case (phase % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 73;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 73;
				end
				default: begin
					send_idle_pct  = 19;
					recv_stall_pct = 19;
				end
			endcase
			burst = $urandom_range(40, 100);
			for (int i = 0; i < burst && sent < ITEM_COUNT; i++) begin
				// in the sender-gap phase, halfway through the burst the sender holds off until the pipeline is empty
				if (phase % 4 == 1 && i == burst / 2)
					drain_results();
				if ($urandom_range(0, 4) == 0)
					raw = 16'($urandom());
				else
					raw = 16'(longint'(base) + longint'($urandom_range(0, 2 * spread))
						- longint'(spread));
				push_pixel(raw, ($urandom_range(0, 7) == 0));
				sent++;
			end
			phase++;
		end

		drain_results();
		repeat (TAIL_WAIT) @(posedge clk);
		if (mismatches == 0 && in_flight == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== pixel_window_level_mapper_top.f =====
src/wlm_pkg.sv
src/wlm_rescale.sv
src/wlm_divider.sv
src/pixel_window_level_mapper_top.sv
tb/wlm_window_checker.sv
tb/tb_pixel_window_level_mapper_top.sv
